[rtl/fbpool_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpool_pkg
// Shared types and constants of the first-fit free buffer pool.
// ----------------------------------------------------------------------------
package fbpool_pkg;

  localparam int POOL_DEPTH = 32;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int ENTRY_W    = 2 * DATA_W;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    OUT_FIT      = 3'd0,
    OUT_GROWN    = 3'd1,
    OUT_MAKE_NEW = 3'd2,
    OUT_KEPT     = 3'd3,
    OUT_DROPPED  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic release_op;
    logic empty_res;
    logic scan_start;
    logic scan;
    logic move_rd;
    logic move_wr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic empty;
    logic scan_hit;
    logic scan_last;
    logic need_move;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/fbpool_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpool_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbpool_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/fbpool_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpool_ctrl
// Sequencer of the buffer pool: dispatch, scan, slot move and result handoff.
// ----------------------------------------------------------------------------
module fbpool_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  fbpool_pkg::dp_status_t status,
  output fbpool_pkg::ctrl_cmd_t  cmd
);

  fbpool_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbpool_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      fbpool_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = fbpool_pkg::S_DISPATCH;
        end
      end
      fbpool_pkg::S_DISPATCH: begin
        if (status.is_release) begin
          cmd.release_op = 1'b1;
          state_nxt      = fbpool_pkg::S_FINISH;
        end else if (status.empty) begin
          cmd.empty_res = 1'b1;
          state_nxt     = fbpool_pkg::S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = fbpool_pkg::S_SCAN;
        end
      end
      fbpool_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_hit || status.scan_last) begin
          state_nxt = fbpool_pkg::S_MOVE_RD;
        end
      end
      fbpool_pkg::S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_nxt   = status.need_move ? fbpool_pkg::S_MOVE_WR : fbpool_pkg::S_FINISH;
      end
      fbpool_pkg::S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = fbpool_pkg::S_FINISH;
      end
      fbpool_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fbpool_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fbpool_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/fbpool_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpool_dp
// Pool datapath: entry memory, fill count, first-fit scan and result register.
// ----------------------------------------------------------------------------
module fbpool_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_operation,
  input  logic [fbpool_pkg::DATA_W-1:0]       in_size_bytes,
  input  logic [fbpool_pkg::DATA_W-1:0]       in_buffer_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_outcome,
  output logic [fbpool_pkg::DATA_W-1:0]       out_granted_address,
  output logic [fbpool_pkg::DATA_W-1:0]       out_granted_size,
  output logic [fbpool_pkg::DATA_W-1:0]       out_grown_from_size,
  input  fbpool_pkg::ctrl_cmd_t               cmd,
  output fbpool_pkg::dp_status_t              status
);

  localparam int DW = fbpool_pkg::DATA_W;
  localparam int IW = fbpool_pkg::IDX_W;
  localparam int CW = fbpool_pkg::CNT_W;

  // request registers
  logic          op_r;
  logic [DW-1:0] size_r, addr_r;

  // pool and scan state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [DW-1:0] best_size_r, best_size_nxt;
  logic [DW-1:0] best_addr_r, best_addr_nxt;
  logic [IW-1:0] best_slot_r, best_slot_nxt;
  logic [IW-1:0] slot_r, slot_nxt;

  // pending result
  fbpool_pkg::outcome_t res_outcome_r, res_outcome_nxt;
  logic [DW-1:0] res_addr_r, res_addr_nxt;
  logic [DW-1:0] res_size_r, res_size_nxt;
  logic [DW-1:0] res_from_r, res_from_nxt;

  // output register
  logic          out_valid_r;
  logic [2:0]    out_outcome_r;
  logic [DW-1:0] out_addr_r, out_size_r, out_from_r;

  // memory ports
  logic                              ram_we, ram_re;
  logic [IW-1:0]                     ram_waddr, ram_raddr;
  logic [fbpool_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [DW-1:0]                     ent_addr, ent_size;

  logic [CW-1:0] last_idx;
  logic          full, best_upd;

  fbpool_ram #(
    .WIDTH (fbpool_pkg::ENTRY_W),
    .DEPTH (fbpool_pkg::POOL_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign ent_addr = ram_rdata[fbpool_pkg::ENTRY_W-1:DW];
  assign ent_size = ram_rdata[DW-1:0];
  assign last_idx = count_r - CW'(1);
  assign full     = (count_r == CW'(fbpool_pkg::POOL_DEPTH));
  assign best_upd = cmp_valid_r && ((ent_size > best_size_r) || (cmp_idx_r == '0));

  assign status.is_release = (op_r == fbpool_pkg::OP_RELEASE);
  assign status.empty      = (count_r == '0);
  assign status.scan_hit   = cmp_valid_r && (ent_size >= size_r);
  assign status.scan_last  = cmp_valid_r && (CW'(cmp_idx_r) == last_idx);
  assign status.need_move  = (CW'(slot_r) < last_idx);
  assign status.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_valid_nxt   = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    best_size_nxt   = best_upd ? ent_size : best_size_r;
    best_addr_nxt   = best_upd ? ent_addr : best_addr_r;
    best_slot_nxt   = best_upd ? cmp_idx_r : best_slot_r;
    slot_nxt        = slot_r;
    res_outcome_nxt = res_outcome_r;
    res_addr_nxt    = res_addr_r;
    res_size_nxt    = res_size_r;
    res_from_nxt    = res_from_r;
    ram_we          = 1'b0;
    ram_waddr       = count_r[IW-1:0];
    ram_wdata       = {addr_r, size_r};
    ram_re          = 1'b0;
    ram_raddr       = rd_idx_r[IW-1:0];

    if (cmd.release_op) begin
      res_addr_nxt = '0;
      res_size_nxt = '0;
      res_from_nxt = '0;
      if (full) begin
        res_outcome_nxt = fbpool_pkg::OUT_DROPPED;
      end else begin
        res_outcome_nxt = fbpool_pkg::OUT_KEPT;
        ram_we          = 1'b1;
        count_nxt       = count_r + CW'(1);
      end
    end

    if (cmd.empty_res) begin
      res_outcome_nxt = fbpool_pkg::OUT_MAKE_NEW;
      res_addr_nxt    = '0;
      res_size_nxt    = size_r;
      res_from_nxt    = '0;
    end

    if (cmd.scan_start) begin
      rd_idx_nxt    = '0;
      best_size_nxt = '0;
      best_addr_nxt = '0;
      best_slot_nxt = '0;
    end

    if (cmd.scan) begin
      if (rd_idx_r < count_r) begin
        ram_re        = 1'b1;
        rd_idx_nxt    = rd_idx_r + CW'(1);
        cmp_valid_nxt = 1'b1;
        cmp_idx_nxt   = rd_idx_r[IW-1:0];
      end
      if (status.scan_hit) begin
        slot_nxt        = cmp_idx_r;
        res_outcome_nxt = fbpool_pkg::OUT_FIT;
        res_addr_nxt    = ent_addr;
        res_size_nxt    = ent_size;
        res_from_nxt    = '0;
      end else if (status.scan_last) begin
        slot_nxt        = best_slot_nxt;
        res_outcome_nxt = fbpool_pkg::OUT_GROWN;
        res_addr_nxt    = best_addr_nxt;
        res_size_nxt    = size_r;
        res_from_nxt    = best_size_nxt;
      end
    end

    if (cmd.move_rd) begin
      count_nxt = last_idx;
      ram_raddr = last_idx[IW-1:0];
      ram_re    = status.need_move;
    end

    if (cmd.move_wr) begin
      ram_we    = 1'b1;
      ram_waddr = slot_r;
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      size_r <= in_size_bytes;
      addr_r <= in_buffer_address;
    end
    rd_idx_r      <= rd_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    best_size_r   <= best_size_nxt;
    best_addr_r   <= best_addr_nxt;
    best_slot_r   <= best_slot_nxt;
    slot_r        <= slot_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_addr_r    <= res_addr_nxt;
    res_size_r    <= res_size_nxt;
    res_from_r    <= res_from_nxt;
    if (cmd.out_load) begin
      out_outcome_r <= res_outcome_r;
      out_addr_r    <= res_addr_r;
      out_size_r    <= res_size_r;
      out_from_r    <= res_from_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_size    = out_size_r;
  assign out_grown_from_size = out_from_r;

endmodule

[rtl/free_buffer_pool_first_fit_top.sv]
`timescale 1ns / 1ps
// path: a release or empty-pool request goes from accept through DISPATCH and FINISH;
//   a scanning request adds SCAN (one entry per cycle), MOVE_RD and, if needed, MOVE_WR
// throughput: one transaction at a time, set by the serial scan of the entry RAM
// the output register lets a finished result wait while the next transaction is taken
// reset: synchronous active low, pool empty, no result pending
// ----------------------------------------------------------------------------
// free_buffer_pool_first_fit_top
// First-fit free buffer pool: hands out, grows and takes back buffers.
// ----------------------------------------------------------------------------
module free_buffer_pool_first_fit_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [fbpool_pkg::DATA_W-1:0] in_size_bytes,
  input  logic [fbpool_pkg::DATA_W-1:0] in_buffer_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_outcome,
  output logic [fbpool_pkg::DATA_W-1:0] out_granted_address,
  output logic [fbpool_pkg::DATA_W-1:0] out_granted_size,
  output logic [fbpool_pkg::DATA_W-1:0] out_grown_from_size
);

  fbpool_pkg::ctrl_cmd_t  cmd;
  fbpool_pkg::dp_status_t status;

  fbpool_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fbpool_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_operation        (in_operation),
    .in_size_bytes       (in_size_bytes),
    .in_buffer_address   (in_buffer_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_outcome         (out_outcome),
    .out_granted_address (out_granted_address),
    .out_granted_size    (out_granted_size),
    .out_grown_from_size (out_grown_from_size),
    .cmd                 (cmd),
    .status              (status)
  );

endmodule

[rtl/fbpool_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpool_checker
// Port-level checks of the buffer pool, bound to the top level.
// ----------------------------------------------------------------------------
module fbpool_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_operation,
  input logic [fbpool_pkg::DATA_W-1:0] in_size_bytes,
  input logic [fbpool_pkg::DATA_W-1:0] in_buffer_address,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [2:0]                    out_outcome,
  input logic [fbpool_pkg::DATA_W-1:0] out_granted_address,
  input logic [fbpool_pkg::DATA_W-1:0] out_granted_size,
  input logic [fbpool_pkg::DATA_W-1:0] out_grown_from_size
);

  // one transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_outcome)
      && $stable(out_granted_address) && $stable(out_granted_size)
      && $stable(out_grown_from_size))
    else $error("stalled result changed");

  // release results carry no buffer
  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == fbpool_pkg::OUT_KEPT
      || out_outcome == fbpool_pkg::OUT_DROPPED)
    |-> out_granted_address == '0 && out_granted_size == '0 && out_grown_from_size == '0)
    else $error("release result carries buffer fields");

  // only a grown buffer reports an old size, empty pool hands out no address
  a_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == fbpool_pkg::OUT_FIT
      || out_outcome == fbpool_pkg::OUT_MAKE_NEW)
    |-> out_grown_from_size == '0)
    else $error("old size reported without growth");

  a_make_new_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == fbpool_pkg::OUT_MAKE_NEW |-> out_granted_address == '0)
    else $error("empty pool result carries an address");

endmodule

bind free_buffer_pool_first_fit_top fbpool_checker u_fbpool_checker (.*);
